[design/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that also holds through reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/twlh_pkg.sv]
// types and constants of the two-wire link handshake unit
package twlh_pkg;

    localparam int TIMEOUT_BITS   = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int PHASE_BITS     = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ANNOUNCE_TIMEOUT  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HANDSHAKE_TIMEOUT = 2'd1;

    localparam logic [TIMEOUT_BITS-1:0] ANNOUNCE_TIMEOUT_RESET  = 16'd10000;
    localparam logic [TIMEOUT_BITS-1:0] HANDSHAKE_TIMEOUT_RESET = 16'd20;

    // opcodes
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_ANNOUNCE = 2'd1;
    localparam logic [1:0] OP_RESPOND  = 2'd2;

    // handshake phases
    localparam logic [PHASE_BITS-1:0] PH_IDLE      = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_A_L2LOW   = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_A_L1LOW   = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_A_L1HIGH  = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_R_L2HIGH  = 3'd4;
    localparam logic [PHASE_BITS-1:0] PH_R_L1LOW   = 3'd5;

    // outcome codes
    localparam logic [2:0] OUT_NONE          = 3'd0;
    localparam logic [2:0] OUT_CONNECTED     = 3'd1;
    localparam logic [2:0] OUT_ANNOUNCE_TO   = 3'd2;
    localparam logic [2:0] OUT_INIT_TO       = 3'd3;
    localparam logic [2:0] OUT_COMPLETE_TO   = 3'd4;
    localparam logic [2:0] OUT_ACK_PRES_TO   = 3'd5;
    localparam logic [2:0] OUT_ACK_HSHAKE_TO = 3'd6;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] side;
        logic       line_one_level;
        logic       line_two_level;
    } in_item_t;

    typedef struct packed {
        logic [2:0] out_side;
        logic       line_one_pull_low;
        logic       line_two_pull_low;
        logic       busy_res;
        logic [2:0] outcome;
    } out_item_t;

    // line drives {line1, line2} held in each phase
    function automatic logic [1:0] phase_drives(input logic [PHASE_BITS-1:0] ph);
        logic [1:0] d;
        case (ph)
            PH_A_L1LOW:  d = 2'b00;
            PH_A_L1HIGH: d = 2'b01;
            PH_R_L1LOW:  d = 2'b01;
            default:     d = 2'b10;
        endcase
        return d;
    endfunction

endpackage

[design/two_wire_link_handshake_unit.sv]
// top level of the two-wire link handshake unit
// path: a transaction accepted on s_ passes through the input register and the result register to m_
// throughput: one transaction per cycle while m_ready keeps the result stage moving, set by the per-side state update
// back-to-back transactions on the same side see each other's updates without stalls
// reset: synchronous active-low aresetn idles every side, clears counters,
// empties both pipeline registers and restores the timeout defaults
module two_wire_link_handshake_unit #(
    parameter int SIDE_COUNT = 6,
    parameter int COUNT_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  twlh_pkg::in_item_t                     s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output twlh_pkg::out_item_t                    m_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [twlh_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [twlh_pkg::TIMEOUT_BITS-1:0]      cfg_data
);

    localparam int SIDE_IDX_BITS = (SIDE_COUNT > 1) ? $clog2(SIDE_COUNT) : 1;
    localparam int SIDE_WIDE_BITS = SIDE_IDX_BITS + 3;
    localparam int CMP_BITS = (COUNT_BITS > twlh_pkg::TIMEOUT_BITS) ?
                              COUNT_BITS : twlh_pkg::TIMEOUT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // input register stage
    logic                     in_valid_reg;
    twlh_pkg::in_item_t       in_reg;

    // result register stage
    logic                     out_valid_reg;
    twlh_pkg::out_item_t      out_reg;
    twlh_pkg::out_item_t      out_next;

    // per-side handshake state
    logic [twlh_pkg::PHASE_BITS-1:0] phase_reg [SIDE_COUNT];
    logic [COUNT_BITS-1:0]           count_reg [SIDE_COUNT];
    logic [twlh_pkg::PHASE_BITS-1:0] phase_next;
    logic [COUNT_BITS-1:0]           count_next;

    // configuration registers
    logic [twlh_pkg::TIMEOUT_BITS-1:0] announce_timeout_reg;
    logic [twlh_pkg::TIMEOUT_BITS-1:0] handshake_timeout_reg;

    logic                            advance;
    logic [SIDE_WIDE_BITS-1:0]       side_wide;
    logic [SIDE_IDX_BITS-1:0]        side_idx;
    logic                            side_in_range;
    logic [twlh_pkg::PHASE_BITS-1:0] cur_phase;
    logic [COUNT_BITS-1:0]           cur_count;
    logic [COUNT_BITS-1:0]           count_inc;
    logic                            met;
    logic [twlh_pkg::PHASE_BITS-1:0] step_phase;
    logic [2:0]                      err_code;
    logic [twlh_pkg::TIMEOUT_BITS-1:0] limit;
    logic                            expired;
    logic [2:0]                      outcome_next;
    logic [1:0]                      drives;

    // the input stage moves on whenever the result register is free or being emptied
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    // side decode, widened so the range check works for any side count
    assign side_wide     = {{SIDE_IDX_BITS{1'b0}}, in_reg.side};
    assign side_idx      = side_wide[SIDE_IDX_BITS-1:0];
    assign side_in_range = side_wide < SIDE_WIDE_BITS'(SIDE_COUNT);

    assign cur_phase = phase_reg[side_idx];
    assign cur_count = count_reg[side_idx];

    // saturating wait counter, expiry at the limit or at saturation
    assign count_inc = (cur_count != COUNT_MAX) ? cur_count + COUNT_BITS'(1) : cur_count;
    assign expired   = (CMP_BITS'(count_inc) >= CMP_BITS'(limit)) || (count_inc == COUNT_MAX);

    // what the current wait looks for, where it leads and how it fails
    always_comb begin
        met        = 1'b0;
        step_phase = twlh_pkg::PH_IDLE;
        err_code   = twlh_pkg::OUT_NONE;
        limit      = handshake_timeout_reg;
        case (cur_phase)
            twlh_pkg::PH_A_L2LOW: begin
                met        = !in_reg.line_two_level;
                step_phase = twlh_pkg::PH_A_L1LOW;
                err_code   = twlh_pkg::OUT_ANNOUNCE_TO;
                limit      = announce_timeout_reg;
            end
            twlh_pkg::PH_A_L1LOW: begin
                met        = !in_reg.line_one_level;
                step_phase = twlh_pkg::PH_A_L1HIGH;
                err_code   = twlh_pkg::OUT_INIT_TO;
            end
            twlh_pkg::PH_A_L1HIGH: begin
                met        = in_reg.line_one_level;
                step_phase = twlh_pkg::PH_IDLE;
                err_code   = twlh_pkg::OUT_COMPLETE_TO;
            end
            twlh_pkg::PH_R_L2HIGH: begin
                met        = in_reg.line_two_level;
                step_phase = twlh_pkg::PH_R_L1LOW;
                err_code   = twlh_pkg::OUT_ACK_PRES_TO;
            end
            twlh_pkg::PH_R_L1LOW: begin
                met        = !in_reg.line_one_level;
                step_phase = twlh_pkg::PH_IDLE;
                err_code   = twlh_pkg::OUT_ACK_HSHAKE_TO;
            end
            default: begin
                met = 1'b0;
            end
        endcase
    end

    // per-side state update for the transaction held in the input stage
    always_comb begin
        phase_next   = cur_phase;
        count_next   = cur_count;
        outcome_next = twlh_pkg::OUT_NONE;
        case (in_reg.opcode)
            twlh_pkg::OP_ANNOUNCE: begin
                // a start always restarts, abandoning any running handshake
                phase_next = twlh_pkg::PH_A_L2LOW;
                count_next = '0;
            end
            twlh_pkg::OP_RESPOND: begin
                phase_next = twlh_pkg::PH_R_L2HIGH;
                count_next = '0;
            end
            twlh_pkg::OP_TICK: begin
                if (cur_phase != twlh_pkg::PH_IDLE) begin
                    if (err_code == twlh_pkg::OUT_NONE) begin
                        // unused phase code falls back to idle
                        phase_next = twlh_pkg::PH_IDLE;
                        count_next = '0;
                    end else if (met) begin
                        phase_next = step_phase;
                        count_next = '0;
                        if (step_phase == twlh_pkg::PH_IDLE) begin
                            outcome_next = twlh_pkg::OUT_CONNECTED;
                        end
                    end else if (expired) begin
                        phase_next   = twlh_pkg::PH_IDLE;
                        count_next   = '0;
                        outcome_next = err_code;
                    end else begin
                        count_next = count_inc;
                    end
                end
            end
            default: begin
                // unknown opcode leaves the side untouched
                phase_next = cur_phase;
            end
        endcase
    end

    // result: drives and busy describe the side after the update
    assign drives = twlh_pkg::phase_drives(phase_next);

    always_comb begin
        out_next.out_side = in_reg.side;
        if (side_in_range) begin
            out_next.line_one_pull_low = drives[1];
            out_next.line_two_pull_low = drives[0];
            out_next.busy_res          = (phase_next != twlh_pkg::PH_IDLE);
            out_next.outcome           = outcome_next;
        end else begin
            // sides beyond the configured count report idle and never change
            out_next.line_one_pull_low = 1'b1;
            out_next.line_two_pull_low = 1'b0;
            out_next.busy_res          = 1'b0;
            out_next.outcome           = twlh_pkg::OUT_NONE;
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    // per-side state, written only for sides inside the configured count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SIDE_COUNT; i++) begin
                phase_reg[i] <= twlh_pkg::PH_IDLE;
                count_reg[i] <= '0;
            end
        end else if (advance && side_in_range) begin
            phase_reg[side_idx] <= phase_next;
            count_reg[side_idx] <= count_next;
        end
    end

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            announce_timeout_reg  <= twlh_pkg::ANNOUNCE_TIMEOUT_RESET;
            handshake_timeout_reg <= twlh_pkg::HANDSHAKE_TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                twlh_pkg::CFG_ANNOUNCE_TIMEOUT:  announce_timeout_reg  <= cfg_data;
                twlh_pkg::CFG_HANDSHAKE_TIMEOUT: handshake_timeout_reg <= cfg_data;
                default: begin
                    announce_timeout_reg <= announce_timeout_reg;
                end
            endcase
        end
    end

endmodule

[design/twlh_checker.sv]
// port-level checker for the two-wire link handshake unit and its bind
`include "assert_macros.svh"

module twlh_checker #(
    parameter int SIDE_COUNT = 6
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input twlh_pkg::out_item_t m_data
);

    // a stalled result stays offered
    `ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid)

    // reset empties the result stage
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

    // any outcome ends the handshake with idle drives
    `ASSERT_IMPLY(a_outcome_idle, aclk, aresetn, m_valid && (m_data.outcome != twlh_pkg::OUT_NONE), !m_data.busy_res && m_data.line_one_pull_low && !m_data.line_two_pull_low)

    // a side outside a handshake shows idle drives
    `ASSERT_IMPLY(a_idle_drives, aclk, aresetn, m_valid && !m_data.busy_res, m_data.line_one_pull_low && !m_data.line_two_pull_low)

    // sides beyond the count are never busy and never report
    `ASSERT_IMPLY(a_side_range, aclk, aresetn, m_valid && (int'(m_data.out_side) >= SIDE_COUNT), !m_data.busy_res && (m_data.outcome == twlh_pkg::OUT_NONE))

endmodule

bind two_wire_link_handshake_unit twlh_checker #(
    .SIDE_COUNT(SIDE_COUNT)
) u_twlh_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[tb/tb_two_wire_link_handshake_unit.sv]
// testbench of the two-wire link handshake unit: directed and random checks against a predictor
`timescale 1ns / 100ps

module tb_two_wire_link_handshake_unit;

    localparam int SIDES      = 6;
    localparam int CNT_BITS   = 16;
    localparam int CYCLE_CAP  = 300000;
    localparam int TAIL_WAIT  = 10;
    localparam int SHOW_LIMIT = 10;

    // opcode the block ignores, and register indexes it has no register for
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [twlh_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_LOW  = 2'd2;
    localparam logic [twlh_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_HIGH = 2'd3;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // block ports, all driven to known values from time zero
    logic                                   s_valid   = 1'b0;
    logic                                   s_ready;
    twlh_pkg::in_item_t                     s_data    = '0;
    logic                                   m_valid;
    logic                                   m_ready   = 1'b0;
    twlh_pkg::out_item_t                    m_data;
    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic [twlh_pkg::CFG_INDEX_BITS-1:0]    cfg_index = '0;
    logic [twlh_pkg::TIMEOUT_BITS-1:0]      cfg_data  = '0;

    two_wire_link_handshake_unit #(
        .SIDE_COUNT(SIDES),
        .COUNT_BITS(CNT_BITS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of per-side state and the timeout registers
    logic [twlh_pkg::PHASE_BITS-1:0]   side_phase [SIDES];
    logic [CNT_BITS-1:0]               side_wait  [SIDES];
    logic [twlh_pkg::TIMEOUT_BITS-1:0] announce_limit;
    logic [twlh_pkg::TIMEOUT_BITS-1:0] handshake_limit;

    // results still owed by the block, oldest first
    twlh_pkg::out_item_t expected_results [$];

    int send_gap_pct    = 0;
    int recv_stall_pct  = 0;
    int items_sent      = 0;
    int useful_sent     = 0;
    int results_checked = 0;
    int connects_seen   = 0;
    int timeouts_seen   = 0;
    int settings_used   = 1;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    // watchdog: a hung handshake or a lost result ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("tb_two_wire_link_handshake_unit NOT OK");
            $finish;
        end
    end

    // receiver side: random back-pressure on the result channel
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // compare every result transaction with the oldest prediction
    always @(posedge aclk) begin : result_check
        twlh_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT)
                    $display("unexpected result: side %0d drives %b%b busy %b outcome %0d",
                             m_data.out_side, m_data.line_one_pull_low,
                             m_data.line_two_pull_low, m_data.busy_res, m_data.outcome);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (m_data.out_side !== want.out_side ||
                    m_data.line_one_pull_low !== want.line_one_pull_low ||
                    m_data.line_two_pull_low !== want.line_two_pull_low ||
                    m_data.busy_res !== want.busy_res ||
                    m_data.outcome !== want.outcome) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT) begin
                        $display("result %0d mismatch: expected side %0d drives %b%b busy %b %s",
                                 results_checked, want.out_side, want.line_one_pull_low,
                                 want.line_two_pull_low, want.busy_res, "and");
                        $display("  outcome %0d, got side %0d drives %b%b busy %b outcome %0d",
                                 want.outcome, m_data.out_side, m_data.line_one_pull_low,
                                 m_data.line_two_pull_low, m_data.busy_res, m_data.outcome);
                    end
                end
                if (want.outcome == twlh_pkg::OUT_CONNECTED)
                    connects_seen++;
                else if (want.outcome != twlh_pkg::OUT_NONE)
                    timeouts_seen++;
            end
        end
    end

    // advance one side of the predictor by one transaction, return the result it owes
    function automatic twlh_pkg::out_item_t advance_link(input twlh_pkg::in_item_t item);
        twlh_pkg::out_item_t               res;
        logic [twlh_pkg::PHASE_BITS-1:0]   ph;
        logic [twlh_pkg::PHASE_BITS-1:0]   nxt;
        logic [2:0]                        err;
        logic                              hit;
        logic [CNT_BITS-1:0]               cnt;
        logic [twlh_pkg::TIMEOUT_BITS-1:0] lim;
        res.out_side          = item.side;
        res.line_one_pull_low = 1'b1;
        res.line_two_pull_low = 1'b0;
        res.busy_res          = 1'b0;
        res.outcome           = twlh_pkg::OUT_NONE;
        if (int'(item.side) < SIDES) begin
            ph = side_phase[item.side];
            if (item.opcode == twlh_pkg::OP_ANNOUNCE) begin
                side_phase[item.side] = twlh_pkg::PH_A_L2LOW;
                side_wait[item.side]  = '0;
            end else if (item.opcode == twlh_pkg::OP_RESPOND) begin
                side_phase[item.side] = twlh_pkg::PH_R_L2HIGH;
                side_wait[item.side]  = '0;
            end else if (item.opcode == twlh_pkg::OP_TICK && ph != twlh_pkg::PH_IDLE) begin
                lim = handshake_limit;
                hit = 1'b0;
                nxt = twlh_pkg::PH_IDLE;
                err = twlh_pkg::OUT_NONE;
                case (ph)
                    twlh_pkg::PH_A_L2LOW: begin
                        hit = !item.line_two_level;
                        nxt = twlh_pkg::PH_A_L1LOW;
                        err = twlh_pkg::OUT_ANNOUNCE_TO;
                        lim = announce_limit;
                    end
                    twlh_pkg::PH_A_L1LOW: begin
                        hit = !item.line_one_level;
                        nxt = twlh_pkg::PH_A_L1HIGH;
                        err = twlh_pkg::OUT_INIT_TO;
                    end
                    twlh_pkg::PH_A_L1HIGH: begin
                        hit = item.line_one_level;
                        err = twlh_pkg::OUT_COMPLETE_TO;
                    end
                    twlh_pkg::PH_R_L2HIGH: begin
                        hit = item.line_two_level;
                        nxt = twlh_pkg::PH_R_L1LOW;
                        err = twlh_pkg::OUT_ACK_PRES_TO;
                    end
                    twlh_pkg::PH_R_L1LOW: begin
                        hit = !item.line_one_level;
                        err = twlh_pkg::OUT_ACK_HSHAKE_TO;
                    end
                    default: ;
                endcase
                if (err == twlh_pkg::OUT_NONE) begin
                    // unknown phase falls back to idle silently
                    side_phase[item.side] = twlh_pkg::PH_IDLE;
                    side_wait[item.side]  = '0;
                end else if (hit) begin
                    side_phase[item.side] = nxt;
                    side_wait[item.side]  = '0;
                    if (nxt == twlh_pkg::PH_IDLE)
                        res.outcome = twlh_pkg::OUT_CONNECTED;
                end else begin
                    cnt = side_wait[item.side];
                    if (cnt != '1)
                        cnt = cnt + 1'b1;
                    // saturated counter also counts as expiry
                    if (cnt >= lim || cnt == '1) begin
                        side_phase[item.side] = twlh_pkg::PH_IDLE;
                        side_wait[item.side]  = '0;
                        res.outcome = err;
                    end else begin
                        side_wait[item.side] = cnt;
                    end
                end
            end
            case (side_phase[item.side])
                twlh_pkg::PH_A_L1LOW:
                    {res.line_one_pull_low, res.line_two_pull_low} = 2'b00;
                twlh_pkg::PH_A_L1HIGH:
                    {res.line_one_pull_low, res.line_two_pull_low} = 2'b01;
                twlh_pkg::PH_R_L1LOW:
                    {res.line_one_pull_low, res.line_two_pull_low} = 2'b01;
                default:
                    {res.line_one_pull_low, res.line_two_pull_low} = 2'b10;
            endcase
            res.busy_res = (side_phase[item.side] != twlh_pkg::PH_IDLE);
        end
        return res;
    endfunction

    function automatic twlh_pkg::in_item_t make_item(input logic [1:0] op,
                                                     input logic [2:0] side,
                                                     input logic l1, input logic l2);
        twlh_pkg::in_item_t it;
        it.opcode         = op;
        it.side           = side;
        it.line_one_level = l1;
        it.line_two_level = l2;
        return it;
    endfunction

    // tick with one line at a chosen level, the other line random
    function automatic twlh_pkg::in_item_t tick_item(input logic [2:0] side,
                                                     input bit on_line_two,
                                                     input logic lvl);
        twlh_pkg::in_item_t it;
        it = make_item(twlh_pkg::OP_TICK, side, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        if (on_line_two)
            it.line_two_level = lvl;
        else
            it.line_one_level = lvl;
        return it;
    endfunction

    // unrestricted transaction: any opcode, any side, any levels
    function automatic twlh_pkg::in_item_t noise_item();
        return make_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    // one input transaction, with random gaps ahead of it
    task automatic send_item(input twlh_pkg::in_item_t item);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(advance_link(item));
        items_sent++;
        if (item.opcode != OP_UNUSED && int'(item.side) < SIDES)
            useful_sent++;
    endtask

    // hold the sender until every owed result has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(input logic [twlh_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [twlh_pkg::TIMEOUT_BITS-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == twlh_pkg::CFG_ANNOUNCE_TIMEOUT)
            announce_limit = val;
        else if (idx == twlh_pkg::CFG_HANDSHAKE_TIMEOUT)
            handshake_limit = val;
        // keep the lowering of valid apart from any following raise
        @(posedge aclk);
    endtask

    task automatic set_timeouts(input logic [twlh_pkg::TIMEOUT_BITS-1:0] ann,
                                input logic [twlh_pkg::TIMEOUT_BITS-1:0] hs);
        write_reg(twlh_pkg::CFG_ANNOUNCE_TIMEOUT, ann);
        write_reg(twlh_pkg::CFG_HANDSHAKE_TIMEOUT, hs);
        settings_used++;
    endtask

    // a tick on an idle side, ignored opcode, sides past the last one
    task automatic test_idle_and_ignored();
        send_item(make_item(twlh_pkg::OP_TICK, 3'd0, 1'b1, 1'b1));
        send_item(make_item(OP_UNUSED, 3'd1, 1'b0, 1'b0));
        send_item(make_item(twlh_pkg::OP_ANNOUNCE, 3'd6, 1'b1, 1'b0));
        send_item(make_item(twlh_pkg::OP_TICK, 3'd7, 1'b0, 1'b1));
    endtask

    // announcer walks every step and connects
    task automatic test_announce_connect();
        send_item(make_item(twlh_pkg::OP_ANNOUNCE, 3'd2, 1'b1, 1'b1));
        send_item(make_item(twlh_pkg::OP_TICK, 3'd2, 1'b1, 1'b0));
        send_item(make_item(twlh_pkg::OP_TICK, 3'd2, 1'b0, 1'b1));
        send_item(make_item(twlh_pkg::OP_TICK, 3'd2, 1'b1, 1'b0));
    endtask

    // responder walks every step and connects
    task automatic test_respond_connect();
        send_item(make_item(twlh_pkg::OP_RESPOND, 3'd3, 1'b0, 1'b0));
        send_item(make_item(twlh_pkg::OP_TICK, 3'd3, 1'b1, 1'b1));
        send_item(make_item(twlh_pkg::OP_TICK, 3'd3, 1'b0, 1'b0));
    endtask

    // ignored opcode on a busy side, then a restart that drops the running handshake
    task automatic test_restart_and_query();
        send_item(make_item(twlh_pkg::OP_RESPOND, 3'd4, 1'b1, 1'b0));
        send_item(make_item(OP_UNUSED, 3'd4, 1'b1, 1'b1));
        send_item(make_item(twlh_pkg::OP_ANNOUNCE, 3'd4, 1'b0, 1'b1));
    endtask

    // every error code, with a zero and a one-tick timeout
    task automatic test_timeout_codes();
        set_timeouts(16'd0, 16'd1);
        // unused register indexes must leave both timeouts alone
        write_reg(CFG_UNUSED_HIGH, 16'hFFFF);
        write_reg(CFG_UNUSED_LOW, 16'h0000);
        send_item(make_item(twlh_pkg::OP_ANNOUNCE, 3'd0, 1'b0, 1'b0));
        send_item(make_item(twlh_pkg::OP_TICK, 3'd0, 1'b0, 1'b1));
        send_item(make_item(twlh_pkg::OP_RESPOND, 3'd5, 1'b1, 1'b1));
        send_item(make_item(twlh_pkg::OP_TICK, 3'd5, 1'b1, 1'b0));
        send_item(make_item(twlh_pkg::OP_ANNOUNCE, 3'd1, 1'b1, 1'b1));
        send_item(make_item(twlh_pkg::OP_TICK, 3'd1, 1'b0, 1'b0));
        send_item(make_item(twlh_pkg::OP_TICK, 3'd1, 1'b1, 1'b0));
        send_item(make_item(twlh_pkg::OP_ANNOUNCE, 3'd2, 1'b0, 1'b1));
        send_item(make_item(twlh_pkg::OP_TICK, 3'd2, 1'b1, 1'b0));
        send_item(make_item(twlh_pkg::OP_TICK, 3'd2, 1'b0, 1'b0));
        send_item(make_item(twlh_pkg::OP_TICK, 3'd2, 1'b0, 1'b1));
        send_item(make_item(twlh_pkg::OP_RESPOND, 3'd3, 1'b0, 1'b1));
        send_item(make_item(twlh_pkg::OP_TICK, 3'd3, 1'b0, 1'b1));
        send_item(make_item(twlh_pkg::OP_TICK, 3'd3, 1'b1, 1'b1));
    endtask

    // one well-formed handshake with random misses, and now and then a stray transaction
    task automatic run_handshake(input logic [2:0] side, input bit announcer);
        int steps;
        int misses;
        int cap;
        bit on_two;
        logic want;
        logic [twlh_pkg::TIMEOUT_BITS-1:0] lim;
        steps = announcer ? 3 : 2;
        send_item(make_item(announcer ? twlh_pkg::OP_ANNOUNCE : twlh_pkg::OP_RESPOND, side,
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        for (int st = 0; st < steps; st++) begin
            on_two = (st == 0);
            if (announcer)
                want = (st == 2);
            else
                want = (st == 0);
            lim = (announcer && st == 0) ? announce_limit : handshake_limit;
            cap = (lim > 16'd12) ? 12 : int'(lim);
            misses = ($urandom_range(0, 99) < 40) ? 0 : int'($urandom_range(0, cap));
            for (int m = 0; m < misses; m++)
                send_item(tick_item(side, on_two, !want));
            if ($urandom_range(0, 99) < 10)
                send_item(noise_item());
            // expired or abandoned: the rest of the sequence would only be idle ticks
            if (side_phase[side] == twlh_pkg::PH_IDLE)
                break;
            send_item(tick_item(side, on_two, want));
        end
    endtask

    // mostly well-formed handshakes, the rest unrestricted noise
    task automatic test_random_traffic(input int quota, input int gap_pct,
                                       input int stall_pct);
        int target;
        int pause_at;
        bit paused;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        target   = useful_sent + quota;
        pause_at = useful_sent + quota / 2;
        paused   = 1'b0;
        while (useful_sent < target) begin
            if ($urandom_range(0, 99) < 75)
                run_handshake(3'($urandom_range(0, SIDES - 1)), 1'($urandom_range(0, 1)));
            else
                send_item(noise_item());
            // sender holds off once until the block has delivered everything
            if (!paused && useful_sent >= pause_at) begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < SIDES; i++) begin
            side_phase[i] = twlh_pkg::PH_IDLE;
            side_wait[i]  = '0;
        end
        announce_limit  = twlh_pkg::ANNOUNCE_TIMEOUT_RESET;
        handshake_limit = twlh_pkg::HANDSHAKE_TIMEOUT_RESET;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset defaults, then at the short timeouts
        send_gap_pct   = 36;
        recv_stall_pct = 66;
        test_idle_and_ignored();
        test_announce_connect();
        test_respond_connect();
        test_restart_and_query();
        test_timeout_codes();

        // sender idles lightly, receiver stalls heavily
        set_timeouts(16'($urandom_range(1, 12)), 16'($urandom_range(2, 8)));
        test_random_traffic(250, 36, 66);

        // the other way round, at the register extremes
        set_timeouts(16'hFFFF, 16'd1);
        test_random_traffic(250, 66, 36);

        // no idling on either side
        set_timeouts(16'd1, 16'hFFFF);
        test_random_traffic(100, 0, 0);
        set_timeouts(16'($urandom_range(2, 10)), 16'($urandom_range(1, 6)));
        test_random_traffic(150, 0, 0);

        wait_drained();
        recv_stall_pct = 0;
        repeat (TAIL_WAIT) @(posedge aclk);

        $display("%0d transactions sent (%0d acted on), %0d results checked",
                 items_sent, useful_sent, results_checked);
        $display("%0d connections, %0d timeouts, %0d register settings, %0d mismatches",
                 connects_seen, timeouts_seen, settings_used, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb_two_wire_link_handshake_unit OK");
        end else begin
            $display("tb_two_wire_link_handshake_unit NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/twlh_pkg.sv
design/two_wire_link_handshake_unit.sv
design/twlh_checker.sv
tb/tb_two_wire_link_handshake_unit.sv
